@@ sv/mbd_pkg.sv @@
`timescale 1ns / 1ps

package mbd_pkg;

  // Largest source level that the line store is sized for.
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  localparam int unsigned X_W        = $clog2(MAX_WIDTH);
  localparam int unsigned Y_W        = $clog2(MAX_HEIGHT);

  localparam int unsigned SRC_DIM_W  = 13;
  localparam int unsigned DST_DIM_W  = 12;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned COUNT_W    = 23;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN    = 3'd5;

  localparam logic [7:0] OPAQUE_LEVEL = 8'd186;

  typedef logic [3:0][7:0] pixel_t;
  typedef logic [3:0][8:0] pair_sum_t;

endpackage

@@ sv/mipmap_box_downsample_top.sv @@
`timescale 1ns / 1ps

// 2x2 box filter that turns one mipmap level into the next.
// Source pixels enter in raster order on the in_* channel (valid/ready), one
// transaction per pixel. Result pixels leave on the out_* channel; a level
// yields dst_width x dst_height results and the final one carries last_pixel
// and, in four-channel mode, the number of results with alpha >= 186.
// The user sets the level geometry and alpha gain through the cfg_* write port
// while the block is idle; the block itself does not enforce it. Writes to
// indices 0 to 5 restart the level at the first source pixel. Throughput is
// one source pixel per cycle while in_ready_o is high. A line store of pair
// sums, one entry per output column, holds the even source row; it is read
// one pixel ahead of the odd pixel that needs it, so its registered read
// stays hidden. The pixel that completes a block passes a mean stage, then
// an output stage for the alpha multiply, saturation and the opaque count.
// When the receiver stalls, the output register holds its result and the
// mean stage still takes one more; after that in_ready_o drops until the
// output drains. Pixels that only feed the line store or the left pixel keep
// flowing as long as the mean stage has room.
// Reset empties the pipeline, restores the register defaults and restarts the
// level. The line store needs no clearing: every entry is written before use.

module mipmap_box_downsample_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       red_in_i,
  input  logic [7:0]                       green_in_i,
  input  logic [7:0]                       blue_in_i,
  input  logic [7:0]                       alpha_in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [7:0]                       red_out_o,
  output logic [7:0]                       green_out_o,
  output logic [7:0]                       blue_out_o,
  output logic [7:0]                       alpha_out_o,
  output logic [mbd_pkg::COUNT_W-1:0]      opaque_count_o,
  output logic                             last_pixel_o
);
  import mbd_pkg::*;

  // Configuration registers.
  logic [SRC_DIM_W-1:0] src_width_q, src_height_q;
  logic [DST_DIM_W-1:0] dst_width_q, dst_height_q;
  logic                 four_channels_q;
  logic [GAIN_W-1:0]    alpha_gain_q;
  logic                 restart;

  // Effective geometry.
  logic [SRC_DIM_W-1:0] sw, sh;
  logic [DST_DIM_W-1:0] lim_w, lim_h, dw_nz, dh_nz, dw, dh;
  logic                 sw_one, sh_one;

  // Position and neighbor state.
  logic [X_W-1:0] x_q, x_d;
  logic [Y_W-1:0] y_q, y_d;
  logic [SRC_DIM_W-1:0] x_inc;
  logic [Y_W:0]         y_inc;
  pixel_t         left_q, left_d, cur_pix;

  // Line store.
  pair_sum_t             line_mem [LINE_DEPTH];
  pair_sum_t             line_rd_q;
  pair_sum_t             pair_sum;
  logic                  mem_we, mem_re;
  logic [LINE_AW-1:0]    line_addr;

  // Mean stage.
  logic                  in_fire, out_free;
  logic                  emit, is_last;
  logic [1:0]            shift;
  logic [LINE_AW-1:0]    ox;
  logic [Y_W-2:0]        oy;
  logic [3:0][9:0]       sum_sel;
  logic [9:0]            shifted [4];
  pixel_t                mean;
  logic                  a_valid_q;
  pixel_t                a_mean_q;
  logic                  a_last_q;

  // Output stage.
  logic [23:0]           alpha_prod;
  logic [11:0]           alpha_scaled;
  logic [7:0]            alpha_sat;
  logic                  opaque;
  logic [COUNT_W-1:0]    total_q, total_inc;
  logic                  out_valid_q;

  assign restart = cfg_we_i && (cfg_index_i <= CFG_ALPHA_GAIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q     <= SRC_DIM_W'(2);
      src_height_q    <= SRC_DIM_W'(2);
      dst_width_q     <= DST_DIM_W'(1);
      dst_height_q    <= DST_DIM_W'(1);
      four_channels_q <= 1'b1;
      alpha_gain_q    <= GAIN_W'(4096);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:     src_width_q     <= cfg_wdata_i[SRC_DIM_W-1:0];
        CFG_SRC_HEIGHT:    src_height_q    <= cfg_wdata_i[SRC_DIM_W-1:0];
        CFG_DST_WIDTH:     dst_width_q     <= cfg_wdata_i[DST_DIM_W-1:0];
        CFG_DST_HEIGHT:    dst_height_q    <= cfg_wdata_i[DST_DIM_W-1:0];
        CFG_FOUR_CHANNELS: four_channels_q <= cfg_wdata_i[0];
        CFG_ALPHA_GAIN:    alpha_gain_q    <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the programmed sizes into what the hardware can walk.
  always_comb begin
    if (src_width_q == '0) begin
      sw = SRC_DIM_W'(1);
    end else if (src_width_q > SRC_DIM_W'(MAX_WIDTH)) begin
      sw = SRC_DIM_W'(MAX_WIDTH);
    end else begin
      sw = src_width_q;
    end
    if (src_height_q == '0) begin
      sh = SRC_DIM_W'(1);
    end else if (src_height_q > SRC_DIM_W'(MAX_HEIGHT)) begin
      sh = SRC_DIM_W'(MAX_HEIGHT);
    end else begin
      sh = src_height_q;
    end
    sw_one = (sw == SRC_DIM_W'(1));
    sh_one = (sh == SRC_DIM_W'(1));
    lim_w  = sw_one ? DST_DIM_W'(1) : sw[SRC_DIM_W-1:1];
    lim_h  = sh_one ? DST_DIM_W'(1) : sh[SRC_DIM_W-1:1];
    dw_nz  = (dst_width_q == '0) ? DST_DIM_W'(1) : dst_width_q;
    dh_nz  = (dst_height_q == '0) ? DST_DIM_W'(1) : dst_height_q;
    dw     = (dw_nz > lim_w) ? lim_w : dw_nz;
    dh     = (dh_nz > lim_h) ? lim_h : dh_nz;
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !a_valid_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cur_pix[0] = red_in_i;
  assign cur_pix[1] = green_in_i;
  assign cur_pix[2] = blue_in_i;
  assign cur_pix[3] = four_channels_q ? alpha_in_i : 8'd0;

  assign line_addr = x_q[X_W-1:1];

  always_comb begin
    emit    = 1'b0;
    shift   = 2'd0;
    ox      = '0;
    oy      = '0;
    left_d  = left_q;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      pair_sum[i] = {1'b0, left_q[i]} + {1'b0, cur_pix[i]};
      sum_sel[i]  = {2'b00, cur_pix[i]};
    end

    if (sw_one && sh_one) begin
      emit = 1'b1;
    end else if (sw_one) begin
      // Single column: average vertical pairs.
      if (!y_q[0]) begin
        left_d = cur_pix;
      end else begin
        oy = y_q[Y_W-1:1];
        if ({1'b0, oy} < dh) begin
          emit  = 1'b1;
          shift = 2'd1;
          for (int i = 0; i < 4; i++) sum_sel[i] = {1'b0, pair_sum[i]};
        end
      end
    end else if (!x_q[0]) begin
      left_d = cur_pix;
      // Fetch the even row's pair sum now; the odd pixel that needs it is next.
      mem_re = 1'b1;
    end else begin
      ox = x_q[X_W-1:1];
      if ({1'b0, ox} < dw) begin
        if (sh_one) begin
          emit  = 1'b1;
          shift = 2'd1;
          for (int i = 0; i < 4; i++) sum_sel[i] = {1'b0, pair_sum[i]};
        end else if (!y_q[0]) begin
          mem_we = 1'b1;
        end else begin
          oy = y_q[Y_W-1:1];
          if ({1'b0, oy} < dh) begin
            emit  = 1'b1;
            shift = 2'd2;
            for (int i = 0; i < 4; i++) begin
              sum_sel[i] = {1'b0, pair_sum[i]} + {1'b0, line_rd_q[i]};
            end
          end
        end
      end
    end

    for (int i = 0; i < 4; i++) begin
      shifted[i] = sum_sel[i] >> shift;
      mean[i]    = shifted[i][7:0];
    end
    is_last = ({1'b0, ox} == dw - DST_DIM_W'(1)) && ({1'b0, oy} == dh - DST_DIM_W'(1));
  end

  // Next source position with wrap at the end of a row and of the level.
  always_comb begin
    x_inc = {1'b0, x_q} + SRC_DIM_W'(1);
    y_inc = {1'b0, y_q} + (Y_W+1)'(1);
    x_d   = x_q;
    y_d   = y_q;
    if (x_inc >= sw) begin
      x_d = '0;
      y_d = (SRC_DIM_W'(y_inc) >= sh) ? '0 : y_inc[Y_W-1:0];
    end else begin
      x_d = x_inc[X_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && mem_we) begin
      line_mem[line_addr] <= pair_sum;
    end
    if (in_fire && mem_re) begin
      line_rd_q <= line_mem[line_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      left_q <= '0;
    end else if (restart) begin
      x_q <= '0;
      y_q <= '0;
    end else if (in_fire) begin
      x_q    <= x_d;
      y_q    <= y_d;
      left_q <= left_d;
    end
  end

  // Mean stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      a_valid_q <= 1'b1;
    end else if (out_free) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      a_mean_q <= mean;
      a_last_q <= is_last;
    end
  end

  // Alpha scaling: 8.0 mean times Q4.12 gain, fraction dropped, saturated.
  always_comb begin
    alpha_prod   = 24'(a_mean_q[3]) * 24'(alpha_gain_q);
    alpha_scaled = alpha_prod[23:12];
    if (!four_channels_q) begin
      alpha_sat = 8'd0;
    end else if (alpha_scaled > 12'd255) begin
      alpha_sat = 8'd255;
    end else begin
      alpha_sat = alpha_scaled[7:0];
    end
    opaque    = four_channels_q && (alpha_sat >= OPAQUE_LEVEL);
    total_inc = total_q + COUNT_W'(opaque);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else if (restart) begin
      total_q <= '0;
    end else if (out_free) begin
      out_valid_q <= a_valid_q;
      if (a_valid_q) begin
        total_q <= a_last_q ? '0 : total_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && a_valid_q) begin
      red_out_o      <= a_mean_q[0];
      green_out_o    <= a_mean_q[1];
      blue_out_o     <= a_mean_q[2];
      alpha_out_o    <= alpha_sat;
      opaque_count_o <= (a_last_q && four_channels_q) ? total_inc : '0;
      last_pixel_o   <= a_last_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/mbd_checker.sv @@
`timescale 1ns / 1ps

module mbd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [7:0]                  red_out_o,
  input logic [7:0]                  alpha_out_o,
  input logic [mbd_pkg::COUNT_W-1:0] opaque_count_o,
  input logic                        last_pixel_o
);
  import mbd_pkg::*;

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o)
      && $stable(alpha_out_o) && $stable(last_pixel_o) && $stable(opaque_count_o))
    else $error("stalled result changed");

  // The opaque count only appears on the final result of a level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_pixel_o |-> opaque_count_o == '0)
    else $error("opaque count on a result that is not the last");

  // A fresh result follows an accepted pixel through the mean and output registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a source pixel two cycles before");

  // Nothing leaves the block right after reset.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind mipmap_box_downsample_top mbd_checker u_mbd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .red_out_o      (red_out_o),
  .alpha_out_o    (alpha_out_o),
  .opaque_count_o (opaque_count_o),
  .last_pixel_o   (last_pixel_o)
);
